[hw/rtl/bencode_scalar_parser_defines.svh]
// Assertion macros for the bencode scalar parser.
`ifndef BENCODE_SCALAR_PARSER_DEFINES_SVH
`define BENCODE_SCALAR_PARSER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BSP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bencode parser assertion failed");

// Check that cons holds in the cycle after ante.
`define BSP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bencode parser assertion failed");

`endif

[hw/rtl/bsp_pkg.sv]
// Shared constants and types for the bencode scalar parser.
`timescale 1ns / 1ps

package bsp_pkg;

    localparam int ValueW = 64;

    typedef logic [7:0]        byte_t;
    typedef logic [ValueW-1:0] value_t;

    typedef enum logic [1:0] {
        K_BYTE  = 2'd0,
        K_EMPTY = 2'd1,
        K_INT   = 2'd2,
        K_ERR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE     = 3'd0,
        E_BAD_TYPE = 3'd1,
        E_NO_DIGIT = 3'd2,
        E_NO_COLON = 3'd3,
        E_NO_E     = 3'd4,
        E_NEG_BIG  = 3'd5,
        E_OVERFLOW = 3'd6
    } err_t;

    localparam byte_t CH_ZERO  = 8'h30;
    localparam byte_t CH_NINE  = 8'h39;
    localparam byte_t CH_MINUS = 8'h2d;
    localparam byte_t CH_COLON = 8'h3a;
    localparam byte_t CH_E     = 8'h65;
    localparam byte_t CH_I     = 8'h69;
    localparam byte_t CH_D     = 8'h64;
    localparam byte_t CH_L     = 8'h6c;

    localparam value_t NEG_LIMIT = value_t'(1) << (ValueW - 1);

endpackage

[hw/rtl/bencode_scalar_parser.sv]
// Bencode scalar token parser: one byte in per transfer, at most one result out.
// A result is presented from a register in the cycle after the byte that causes it is taken.
// Throughput: one byte per cycle; a byte is taken while a result waits, as long as
// the result register is empty or is emptied in the same cycle.
// Reset (rst_n low, asynchronous): parser idle awaiting a type byte, no result held.
`timescale 1ns / 1ps
`include "bencode_scalar_parser_defines.svh"

module bencode_scalar_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 data_valid,
    output logic                 data_ready,
    input  bsp_pkg::byte_t       data_byte,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [1:0]           kind,
    output bsp_pkg::value_t      value,
    output logic                 is_negative,
    output logic                 last,
    output logic [2:0]           error_code
);

    import bsp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_STR_LEN   = 3'd1,
        PH_STR_DATA  = 3'd2,
        PH_INT_SIGN  = 3'd3,
        PH_INT_FIRST = 3'd4,
        PH_INT_DIGIT = 3'd5
    } phase_t;

    phase_t  phase_reg, phase_next;
    value_t  acc_reg, acc_next;
    logic    minus_reg, minus_next;
    value_t  rem_reg, rem_next;

    logic    out_valid_reg;
    kind_t   kind_reg;
    value_t  value_reg;
    logic    neg_reg;
    logic    last_reg;
    err_t    err_reg;

    logic    res_fire;
    kind_t   res_kind;
    value_t  res_value;
    logic    res_neg;
    logic    res_last;
    err_t    res_err;

    logic               accept;
    logic               is_digit;
    logic [3:0]         digit;
    logic [ValueW+3:0]  acc_x10;
    logic               acc_ovf;
    value_t             rem_dec;

    assign data_ready = !out_valid_reg || result_ready;
    assign accept     = data_valid && data_ready;

    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit    = data_byte[3:0];
    assign acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                    + {{(ValueW){1'b0}}, digit};
    assign acc_ovf  = |acc_x10[ValueW+3:ValueW];
    assign rem_dec  = rem_reg - value_t'(1);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        rem_next   = rem_reg;
        res_fire   = 1'b0;
        res_kind   = K_ERR;
        res_value  = '0;
        res_neg    = 1'b0;
        res_last   = 1'b1;
        res_err    = E_NONE;

        unique case (phase_reg)
            PH_STR_LEN:
            begin
                if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        res_fire = 1'b1;
                        res_err  = E_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = acc_x10[ValueW-1:0];
                    end
                end
                else if (data_byte != CH_COLON)
                begin
                    res_fire = 1'b1;
                    res_err  = E_NO_COLON;
                end
                else if (acc_reg == '0)
                begin
                    res_fire = 1'b1;
                    res_kind = K_EMPTY;
                end
                else
                begin
                    rem_next   = acc_reg;
                    acc_next   = '0;
                    phase_next = PH_STR_DATA;
                end
            end
            PH_STR_DATA:
            begin
                res_fire  = 1'b1;
                res_kind  = K_BYTE;
                res_value = value_t'(data_byte);
                res_last  = (rem_dec == '0);
                rem_next  = rem_dec;
            end
            PH_INT_SIGN, PH_INT_FIRST:
            begin
                if (phase_reg == PH_INT_SIGN && data_byte == CH_MINUS)
                begin
                    minus_next = 1'b1;
                    phase_next = PH_INT_FIRST;
                end
                else if (!is_digit)
                begin
                    res_fire = 1'b1;
                    res_err  = E_NO_DIGIT;
                end
                else
                begin
                    acc_next   = value_t'(digit);
                    phase_next = PH_INT_DIGIT;
                end
            end
            PH_INT_DIGIT:
            begin
                if (is_digit)
                begin
                    if (acc_ovf)
                    begin
                        res_fire = 1'b1;
                        res_err  = E_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = acc_x10[ValueW-1:0];
                    end
                end
                else if (data_byte != CH_E)
                begin
                    res_fire = 1'b1;
                    res_err  = E_NO_E;
                end
                else if (minus_reg && acc_reg > NEG_LIMIT)
                begin
                    res_fire = 1'b1;
                    res_err  = E_NEG_BIG;
                end
                else
                begin
                    res_fire  = 1'b1;
                    res_kind  = K_INT;
                    res_value = minus_reg ? (value_t'(0) - acc_reg) : acc_reg;
                    res_neg   = minus_reg;
                end
            end
            default:
            begin
                acc_next   = '0;
                minus_next = 1'b0;
                rem_next   = '0;
                phase_next = PH_IDLE;
                if (is_digit)
                begin
                    acc_next   = value_t'(digit);
                    phase_next = PH_STR_LEN;
                end
                else if (data_byte == CH_I)
                begin
                    phase_next = PH_INT_SIGN;
                end
                else if (data_byte == CH_D || data_byte == CH_L)
                begin
                    res_fire = 1'b1;
                    res_err  = E_OVERFLOW;
                end
                else
                begin
                    res_fire = 1'b1;
                    res_err  = E_BAD_TYPE;
                end
            end
        endcase

        // drop all token state once the token ends or fails
        if (res_fire && res_last)
        begin
            phase_next = PH_IDLE;
            acc_next   = '0;
            minus_next = 1'b0;
            rem_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            acc_reg       <= '0;
            minus_reg     <= 1'b0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= K_BYTE;
            value_reg     <= '0;
            neg_reg       <= 1'b0;
            last_reg      <= 1'b0;
            err_reg       <= E_NONE;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                minus_reg <= minus_next;
                rem_reg   <= rem_next;
            end
            if (accept)
            begin
                out_valid_reg <= res_fire;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && res_fire)
            begin
                kind_reg  <= res_kind;
                value_reg <= res_value;
                neg_reg   <= res_neg;
                last_reg  <= res_last;
                err_reg   <= res_err;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;
    assign is_negative  = neg_reg;
    assign last         = last_reg;
    assign error_code   = err_reg;

    `BSP_ASSERT_NEXT(a_err_clears_state, accept && res_fire && res_kind == K_ERR,
        phase_reg == PH_IDLE && acc_reg == '0 && rem_reg == '0 && !minus_reg)
    `BSP_ASSERT_IMP(a_err_result_shape, out_valid_reg && kind_reg == K_ERR,
        last_reg && value_reg == '0 && err_reg != E_NONE && !neg_reg)
    `BSP_ASSERT_IMP(a_data_phase_count, phase_reg == PH_STR_DATA, rem_reg != '0)
    `BSP_ASSERT_NEXT(a_result_loaded, accept && res_fire,
        out_valid_reg && kind_reg == $past(res_kind) && last_reg == $past(res_last))

endmodule
